// ===== rtl/ipma_pkg.sv =====
package ipma_pkg;

    // fixed point format of inputs and result
    localparam int FRAC_BITS = 16;

    // wide dividend of the shared divider, large enough for every quotient
    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // 64 x 32 product before rounding
    localparam int ACC_W = 96;

    localparam logic [63:0]      INT64_MAX  = {1'b0, {63{1'b1}}};
    localparam logic [63:0]      INT64_MIN  = {1'b1, 63'b0};
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    localparam logic [31:0] MEAN_POS_LIMIT = 32'h7fff_ffff;
    localparam logic [31:0] MEAN_NEG_LIMIT = 32'h8000_0000;

    // configuration register indexes
    localparam logic CFG_PRIOR_MEAN     = 1'b0;
    localparam logic CFG_PRIOR_VARIANCE = 1'b1;

    localparam logic [30:0] PRIOR_VAR_ONE = 31'(1) << FRAC_BITS;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CAPTURE  = 4'd1;
    localparam logic [3:0] OP_MUL_OT   = 4'd2;
    localparam logic [3:0] OP_MUL_LO   = 4'd3;
    localparam logic [3:0] OP_MUL_HI   = 4'd4;
    localparam logic [3:0] OP_ACCUM    = 4'd5;
    localparam logic [3:0] OP_NUM_PROD = 4'd6;
    localparam logic [3:0] OP_DIV_B    = 4'd7;
    localparam logic [3:0] OP_DIV_R    = 4'd8;
    localparam logic [3:0] OP_DIV_Q    = 4'd9;
    localparam logic [3:0] OP_TAKE_B   = 4'd10;
    localparam logic [3:0] OP_TAKE_R   = 4'd11;
    localparam logic [3:0] OP_TAKE_Q   = 4'd12;
    localparam logic [3:0] OP_SPECIAL  = 4'd13;
    localparam logic [3:0] OP_EMIT     = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic       slope_src;
    } t_cmd;

    typedef struct packed {
        logic missing;
        logic last;
        logic div_done;
        logic den_zero;
        logic out_free;
    } t_status;

    function automatic logic [63:0] neg64(input logic [63:0] x);
        neg64 = ~x + 64'd1;
    endfunction

    // two's complement add, clamped to the signed 64 bit range
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            sat_add64 = a[63] ? INT64_MIN : INT64_MAX;
        end else begin
            sat_add64 = s;
        end
    endfunction

endpackage

// ===== rtl/item_posterior_mean_accumulator_unit.sv =====
// posterior mean accumulator for one item column of a binary logistic model
// input channel: one matrix cell per transaction (response, missing flag,
//   weight, ability, slope, last-row marker), taken when i_in_valid is high
//   and o_in_stall is low
// output channel: one posterior mean per column, emitted after the cell
//   marked last, taken when o_out_valid is high and i_out_stall is low
// cell intake: a cell is taken only while the controller is idle, so a new
//   cell waits until the last one is through the three-step use of the
//   single 32 x 32 multiplier; a missing cell skips those steps
// a column result is offered after the last cell once the close-out is
//   through, plus any wait for the output register; up to three bit-serial
//   divisions on the one shared divider dominate this time
// the result sits in an output register, so new cells are taken while it
//   waits; a stalled receiver only holds the next column at its final step
// configuration writes land at the clock edge with i_cfg_we high, and must
//   only come while no column is in flight
// synchronous reset clears the sums, the controller and the output valid,
//   and sets the prior to mean 0 and variance 1.0
module item_posterior_mean_accumulator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // cell transactions
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_response,
    input  logic               i_response_missing,
    input  logic [31:0]        i_pg_weight,
    input  logic signed [31:0] i_ability,
    input  logic signed [31:0] i_item_slope,
    input  logic               i_last_row,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_posterior_mean,
    output logic               o_saturated,
    // register writes: index 0 prior mean, index 1 prior variance
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ipma_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: walks each non-missing cell through the multiplier steps, then
    // the column close-out through the slope product and the divider steps
    ipma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // sums, shared multiplier, shared divider and output register
    ipma_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_response         (i_response),
        .i_response_missing (i_response_missing),
        .i_pg_weight        (i_pg_weight),
        .i_ability          (i_ability),
        .i_item_slope       (i_item_slope),
        .i_last_row         (i_last_row),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_posterior_mean   (o_posterior_mean),
        .o_saturated        (o_saturated),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

endmodule

// ===== rtl/ipma_div.sv =====
module ipma_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ipma_pkg::NUM_W-1:0] i_numer,
    input  logic [63:0]                i_denom,
    output logic                       o_done,
    output logic [ipma_pkg::NUM_W-1:0] o_quot
);
    import ipma_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0]      r_rem, n_rem;
    logic [63:0]      r_dvs, n_dvs;
    logic [NUM_W-1:0] r_quo, n_quo;

    logic [64:0] rem_sh;
    logic [64:0] rem_dbl;
    logic        fits;

    // restoring division, one quotient bit a cycle, then round to nearest
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_dbl = {r_rem, 1'b0};
        fits    = rem_sh >= {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_rem  = '0;
            n_dvs  = i_denom;
            n_quo  = i_numer;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_rem = fits ? 64'(rem_sh - {1'b0, r_dvs}) : rem_sh[63:0];
                n_quo = {r_quo[NUM_W-2:0], fits};
                n_cnt = r_cnt - CNT_W'(1);
            end else begin
                if (rem_dbl >= {1'b0, r_dvs}) begin
                    n_quo = r_quo + NUM_W'(1);
                end
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/ipma_datapath.sv =====
module ipma_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ipma_pkg::t_cmd          i_cmd,
    output ipma_pkg::t_status       o_status,
    input  logic                    i_response,
    input  logic                    i_response_missing,
    input  logic [31:0]             i_pg_weight,
    input  logic signed [31:0]      i_ability,
    input  logic signed [31:0]      i_item_slope,
    input  logic                    i_last_row,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [31:0]      o_posterior_mean,
    output logic                    o_saturated,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    import ipma_pkg::*;

    // configuration
    logic [31:0] r_prior_mean, n_prior_mean;
    logic [30:0] r_prior_var, n_prior_var;

    // captured transaction
    logic        r_response, n_response;
    logic        r_missing, n_missing;
    logic        r_last, n_last;
    logic [31:0] r_omega, n_omega;
    logic [31:0] r_tmag, n_tmag;
    logic        r_tneg, n_tneg;
    logic [31:0] r_amag, n_amag;
    logic        r_aneg, n_aneg;

    // running sums, signed 64 bit
    logic [63:0] r_swsq, n_swsq;
    logic [63:0] r_swa, n_swa;
    logic [63:0] r_sca, n_sca;

    // working registers
    logic [63:0]      r_ot, n_ot;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [63:0]      r_num, n_num;
    logic [63:0]      r_den, n_den;
    logic [31:0]      r_res, n_res;
    logic             r_sat, n_sat;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_mean, n_out_mean;
    logic        r_out_sat, n_out_sat;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [63:0]      swa_mag;
    logic [ACC_W-1:0] rnd_shift;
    logic [63:0]      rnd_mag;
    logic [31:0]      b0_mag;
    logic [63:0]      b0_var;
    logic [63:0]      num_mag;
    logic [63:0]      cent;
    logic [63:0]      pm_term;
    logic [63:0]      bm;
    logic [63:0]      recip;
    logic [64:0]      den_sum;
    logic [31:0]      q_lim;
    logic [31:0]      q_mag;
    logic             q_over;
    logic             div_start;
    logic [NUM_W-1:0] div_numer;
    logic [63:0]      div_denom;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    assign swa_mag   = r_swa[63] ? neg64(r_swa) : r_swa;
    assign rnd_shift = r_acc >> FRAC_BITS;
    assign rnd_mag   = (|rnd_shift[ACC_W-1:63]) ? INT64_MAX : rnd_shift[63:0];
    assign b0_mag    = r_prior_mean[31] ? (~r_prior_mean + 32'd1) : r_prior_mean;
    assign b0_var    = (r_prior_var == '0) ? 64'd1 : 64'(r_prior_var);
    assign num_mag   = r_num[63] ? neg64(r_num) : r_num;
    assign cent      = 64'(r_tmag) << (FRAC_BITS - 1);

    // shared 32 x 32 multiplier
    always_comb begin
        mul_a = '0;
        mul_b = r_tmag;
        case (i_cmd.op)
            OP_MUL_OT: begin
                mul_a = r_omega;
                mul_b = r_tmag;
            end
            OP_MUL_LO: begin
                mul_a = i_cmd.slope_src ? swa_mag[31:0] : r_ot[31:0];
                mul_b = i_cmd.slope_src ? r_amag : r_tmag;
            end
            OP_MUL_HI: begin
                mul_a = i_cmd.slope_src ? swa_mag[63:32] : r_ot[63:32];
                mul_b = i_cmd.slope_src ? r_amag : r_tmag;
            end
            default: ;
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // divider operand selection
    assign div_start = i_cmd.op inside {OP_DIV_B, OP_DIV_R, OP_DIV_Q};

    always_comb begin
        case (i_cmd.op)
            OP_DIV_B: begin
                div_numer = NUM_W'(b0_mag) << (2 * FRAC_BITS);
                div_denom = b0_var;
            end
            OP_DIV_R: begin
                div_numer = NUM_W'(1) << (3 * FRAC_BITS);
                div_denom = b0_var;
            end
            default: begin
                div_numer = NUM_W'(num_mag) << FRAC_BITS;
                div_denom = r_den;
            end
        endcase
    end

    ipma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // quotient clamps
    assign bm      = (|div_quot[NUM_W-1:63]) ? INT64_MAX : div_quot[63:0];
    assign recip   = (|div_quot[NUM_W-1:64]) ? {64{1'b1}} : div_quot[63:0];
    assign den_sum = {1'b0, r_swsq} + {1'b0, recip};
    assign q_lim   = r_num[63] ? MEAN_NEG_LIMIT : MEAN_POS_LIMIT;
    assign q_over  = (|div_quot[NUM_W-1:32]) || (div_quot[31:0] > q_lim);
    assign q_mag   = q_over ? q_lim : div_quot[31:0];
    assign pm_term = (r_swa[63] ^ r_aneg) ? rnd_mag : neg64(rnd_mag);

    always_comb begin
        n_prior_mean = r_prior_mean;
        n_prior_var  = r_prior_var;
        n_response   = r_response;
        n_missing    = r_missing;
        n_last       = r_last;
        n_omega      = r_omega;
        n_tmag       = r_tmag;
        n_tneg       = r_tneg;
        n_amag       = r_amag;
        n_aneg       = r_aneg;
        n_swsq       = r_swsq;
        n_swa        = r_swa;
        n_sca        = r_sca;
        n_ot         = r_ot;
        n_acc        = r_acc;
        n_num        = r_num;
        n_den        = r_den;
        n_res        = r_res;
        n_sat        = r_sat;
        n_out_valid  = r_out_valid;
        n_out_mean   = r_out_mean;
        n_out_sat    = r_out_sat;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRIOR_MEAN:     n_prior_mean = i_cfg_data;
                CFG_PRIOR_VARIANCE: n_prior_var  = i_cfg_data[30:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (i_cmd.op)
            OP_CAPTURE: begin
                n_response = i_response;
                n_missing  = i_response_missing;
                n_last     = i_last_row;
                n_omega    = i_pg_weight;
                n_tneg     = i_ability[31];
                n_tmag     = i_ability[31] ? (~i_ability + 32'd1) : i_ability;
                n_aneg     = i_item_slope[31];
                n_amag     = i_item_slope[31] ? (~i_item_slope + 32'd1) : i_item_slope;
            end
            OP_MUL_OT: n_ot = mul_p;
            OP_MUL_LO: n_acc = ACC_W'(mul_p) + ROUND_HALF;
            OP_MUL_HI: n_acc = r_acc + (ACC_W'(mul_p) << 32);
            OP_ACCUM: begin
                n_swa  = sat_add64(r_swa, r_tneg ? neg64(r_ot) : r_ot);
                n_swsq = sat_add64(r_swsq, rnd_mag);
                n_sca  = sat_add64(r_sca, (r_tneg ^ !r_response) ? neg64(cent) : cent);
            end
            OP_NUM_PROD: n_num = sat_add64(r_sca, pm_term);
            OP_TAKE_B:   n_num = sat_add64(r_num, r_prior_mean[31] ? neg64(bm) : bm);
            OP_TAKE_R:   n_den = den_sum[64] ? {64{1'b1}} : den_sum[63:0];
            OP_TAKE_Q: begin
                n_sat = q_over;
                n_res = r_num[63] ? (~q_mag + 32'd1) : q_mag;
            end
            OP_SPECIAL: begin
                // nothing on the denominator side
                n_sat = (r_num != '0);
                if (r_num == '0) begin
                    n_res = '0;
                end else begin
                    n_res = r_num[63] ? MEAN_NEG_LIMIT : MEAN_POS_LIMIT;
                end
            end
            OP_EMIT: begin
                n_out_valid = 1'b1;
                n_out_mean  = r_res;
                n_out_sat   = r_sat;
                n_swsq      = '0;
                n_swa       = '0;
                n_sca       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_mean <= '0;
            r_prior_var  <= PRIOR_VAR_ONE;
            r_swsq       <= '0;
            r_swa        <= '0;
            r_sca        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prior_mean <= n_prior_mean;
            r_prior_var  <= n_prior_var;
            r_swsq       <= n_swsq;
            r_swa        <= n_swa;
            r_sca        <= n_sca;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_response <= n_response;
        r_missing  <= n_missing;
        r_last     <= n_last;
        r_omega    <= n_omega;
        r_tmag     <= n_tmag;
        r_tneg     <= n_tneg;
        r_amag     <= n_amag;
        r_aneg     <= n_aneg;
        r_ot       <= n_ot;
        r_acc      <= n_acc;
        r_num      <= n_num;
        r_den      <= n_den;
        r_res      <= n_res;
        r_sat      <= n_sat;
        r_out_mean <= n_out_mean;
        r_out_sat  <= n_out_sat;
    end

    assign o_status.missing  = r_missing;
    assign o_status.last     = r_last;
    assign o_status.div_done = div_done;
    assign o_status.den_zero = (r_den == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_posterior_mean = $signed(r_out_mean);
    assign o_saturated      = r_out_sat;

endmodule

// ===== rtl/ipma_ctrl.sv =====
module ipma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output ipma_pkg::t_cmd    o_cmd,
    input  ipma_pkg::t_status i_status
);
    import ipma_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_OT  = 4'd1;
    localparam logic [3:0] S_MUL_LO  = 4'd2;
    localparam logic [3:0] S_MUL_HI  = 4'd3;
    localparam logic [3:0] S_ACCUM   = 4'd4;
    localparam logic [3:0] S_PM_LO   = 4'd5;
    localparam logic [3:0] S_PM_HI   = 4'd6;
    localparam logic [3:0] S_PM_NUM  = 4'd7;
    localparam logic [3:0] S_DIVB_GO = 4'd8;
    localparam logic [3:0] S_DIVB    = 4'd9;
    localparam logic [3:0] S_DIVR_GO = 4'd10;
    localparam logic [3:0] S_DIVR    = 4'd11;
    localparam logic [3:0] S_CHECK   = 4'd12;
    localparam logic [3:0] S_DIVQ    = 4'd13;
    localparam logic [3:0] S_EMIT    = 4'd14;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = OP_NONE;
        o_cmd.slope_src = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_MUL_OT;
                end
            end
            S_MUL_OT: begin
                // a missing cell adds nothing
                if (i_status.missing) begin
                    n_state = i_status.last ? S_PM_LO : S_IDLE;
                end else begin
                    o_cmd.op = OP_MUL_OT;
                    n_state  = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.op = OP_ACCUM;
                n_state  = i_status.last ? S_PM_LO : S_IDLE;
            end
            S_PM_LO: begin
                o_cmd.op        = OP_MUL_LO;
                o_cmd.slope_src = 1'b1;
                n_state         = S_PM_HI;
            end
            S_PM_HI: begin
                o_cmd.op        = OP_MUL_HI;
                o_cmd.slope_src = 1'b1;
                n_state         = S_PM_NUM;
            end
            S_PM_NUM: begin
                o_cmd.op        = OP_NUM_PROD;
                o_cmd.slope_src = 1'b1;
                n_state         = S_DIVB_GO;
            end
            S_DIVB_GO: begin
                o_cmd.op = OP_DIV_B;
                n_state  = S_DIVB;
            end
            S_DIVB: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_TAKE_B;
                    n_state  = S_DIVR_GO;
                end
            end
            S_DIVR_GO: begin
                o_cmd.op = OP_DIV_R;
                n_state  = S_DIVR;
            end
            S_DIVR: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_TAKE_R;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.den_zero) begin
                    o_cmd.op = OP_SPECIAL;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.op = OP_DIV_Q;
                    n_state  = S_DIVQ;
                end
            end
            S_DIVQ: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_TAKE_Q;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/ipma_checker.sv =====
module ipma_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_posterior_mean,
    input logic               o_saturated
);

    // a stalled result stays offered
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_posterior_mean) && $stable(o_saturated))
        else $error("result changed while stalled");

    // every taken cell keeps the block busy in the cycle after it is taken
    a_busy_after_take : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("cell taken on consecutive cycles");

    // a clamped result is one of the two bounds
    a_clamp_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_posterior_mean == 32'sh7fff_ffff || o_posterior_mean == 32'sh8000_0000))
        else $error("saturated result is not a bound");

    // reset leaves the block idle with nothing offered
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind item_posterior_mean_accumulator_unit ipma_checker u_ipma_checker (.*);
